// File: rtl/rgb565_rect_line_draw_engine_assert.svh
// Assertion helpers shared by the drawing engine modules.
`ifndef RGB565_RECT_LINE_DRAW_ENGINE_ASSERT_SVH
`define RGB565_RECT_LINE_DRAW_ENGINE_ASSERT_SVH

// Checks the consequent in the same cycle as the antecedent.
`define RRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define RRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rrl_pkg.sv
`timescale 1ns / 1ps

package rrl_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int SCR_BITS       = 12;
    localparam int DIM_BITS       = 13;
    localparam int ADDR_BITS      = 24;
    localparam int COL_BITS       = 16;
    localparam int RGB_BITS       = 24;
    localparam int KIND_BITS      = 3;
    localparam int LEN_BITS       = 13;

    localparam logic [DIM_BITS-1:0] MAX_SCREEN = 13'd4096;
    localparam logic [DIM_BITS-1:0] STRIDE_RST = 13'd800;
    localparam logic [DIM_BITS-1:0] HEIGHT_RST = 13'd480;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_POINT   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_LINE_H  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_LINE_V  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_OUTLINE = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_FILL    = 3'd4;

    localparam logic [1:0] SEG_TOP    = 2'd0;
    localparam logic [1:0] SEG_BOTTOM = 2'd1;
    localparam logic [1:0] SEG_LEFT   = 2'd2;
    localparam logic [1:0] SEG_RIGHT  = 2'd3;

    localparam logic CFG_STRIDE = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [SCR_BITS-1:0] x;
        logic [SCR_BITS-1:0] y;
        logic [COL_BITS-1:0] colour;
        logic                last;
        logic                rejected;
    } t_pix;

    function automatic logic [DIM_BITS-1:0] eff_dim(logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = {{(DIM_BITS-1){1'b0}}, 1'b1};
        end else if (v > MAX_SCREEN) begin
            r = MAX_SCREEN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [COL_BITS-1:0] to_rgb565(logic [RGB_BITS-1:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

// File: rtl/rrl_fifo.sv
`timescale 1ns / 1ps
`include "rgb565_rect_line_draw_engine_assert.svh"

module rrl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrl_pkg::t_pix i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rrl_pkg::t_pix o_data
);
    import rrl_pkg::*;

    t_pix                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `RRL_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, (i_push && !i_pop), (r_count < FIFO_DEPTH), "queue overflow")
    `RRL_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, (r_count != '0), "queue underflow")

endmodule

// File: rtl/rrl_front.sv
`timescale 1ns / 1ps
`include "rgb565_rect_line_draw_engine_assert.svh"

module rrl_front #(
    parameter int COORD_BITS = rrl_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrl_pkg::DIM_BITS-1:0]  i_width,
    input  logic [rrl_pkg::DIM_BITS-1:0]  i_height,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [rrl_pkg::KIND_BITS-1:0] i_shape_kind,
    input  logic [COORD_BITS-1:0]         i_x_start,
    input  logic [COORD_BITS-1:0]         i_y_start,
    input  logic [COORD_BITS-1:0]         i_x_end,
    input  logic [COORD_BITS-1:0]         i_y_end,
    input  logic [rrl_pkg::LEN_BITS-1:0]  i_line_length,
    input  logic [rrl_pkg::RGB_BITS-1:0]  i_colour_argb,
    input  logic                          i_full,
    output logic                          o_push,
    output rrl_pkg::t_pix                 o_pix
);
    import rrl_pkg::*;

    // Working width for clamping: holds any coordinate, any length and a signed span.
    localparam int VW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;

    typedef logic [VW-1:0] t_val;

    typedef struct packed {
        logic                ok;
        logic [SCR_BITS-1:0] cx;
        logic [SCR_BITS-1:0] cy;
        logic [SCR_BITS-1:0] sx;
        logic [SCR_BITS-1:0] sy;
    } t_seg;

    typedef struct packed {
        logic       ok;
        logic [1:0] seg;
        t_seg       line;
    } t_start;

    function automatic t_seg setup_line(t_val x, t_val y, logic horiz, t_val len,
                                        t_val w, t_val h);
        t_seg r;
        t_val xc;
        t_val yc;
        t_val e;
        xc = (x >= w) ? (w - t_val'(1)) : x;
        yc = (y >= h) ? (h - t_val'(1)) : y;
        r.ok = ($signed(len) > $signed(t_val'(0)));
        r.cx = SCR_BITS'(xc);
        r.cy = SCR_BITS'(yc);
        r.sx = SCR_BITS'(xc);
        r.sy = SCR_BITS'(yc);
        if (horiz) begin
            e = xc + len - t_val'(1);
            if (e >= w) begin
                e = w - t_val'(1);
            end
            r.sx = SCR_BITS'(e);
        end else begin
            e = yc + len - t_val'(1);
            if (e >= h) begin
                e = h - t_val'(1);
            end
            r.sy = SCR_BITS'(e);
        end
        return r;
    endfunction

    // Picks the first outline side at or after 'first' that draws anything.
    function automatic t_start start_seg(t_val left, t_val right, t_val top, t_val bottom,
                                         logic [2:0] first, t_val w, t_val h);
        t_seg   segs [4];
        t_val   xl;
        t_val   yl;
        t_val   top1;
        t_start r;
        xl   = right - left + t_val'(1);
        yl   = bottom - top - t_val'(1);
        top1 = top + t_val'(1);
        segs[SEG_TOP]    = setup_line(left, top, 1'b1, xl, w, h);
        segs[SEG_BOTTOM] = setup_line(left, bottom, 1'b1, xl, w, h);
        segs[SEG_LEFT]   = setup_line(left, top1, 1'b0, yl, w, h);
        segs[SEG_RIGHT]  = setup_line(right, top1, 1'b0, yl, w, h);
        r = '0;
        for (int i = 3; i >= 0; i--) begin
            if ((3'(i) >= first) && segs[i].ok) begin
                r.ok   = 1'b1;
                r.seg  = 2'(i);
                r.line = segs[i];
            end
        end
        return r;
    endfunction

    logic                  r_busy;
    logic [KIND_BITS-1:0]  r_kind;
    logic [1:0]            r_seg;
    logic [SCR_BITS-1:0]   r_cx;
    logic [SCR_BITS-1:0]   r_cy;
    logic [SCR_BITS-1:0]   r_sx;
    logic [SCR_BITS-1:0]   r_sy;
    logic [COORD_BITS-1:0] r_left;
    logic [COORD_BITS-1:0] r_right;
    logic [COORD_BITS-1:0] r_top;
    logic [COORD_BITS-1:0] r_bottom;
    logic [COL_BITS-1:0]   r_colour;

    logic                  n_busy;
    logic [KIND_BITS-1:0]  n_kind;
    logic [1:0]            n_seg;
    logic [SCR_BITS-1:0]   n_cx;
    logic [SCR_BITS-1:0]   n_cy;
    logic [SCR_BITS-1:0]   n_sx;
    logic [SCR_BITS-1:0]   n_sy;
    logic [COORD_BITS-1:0] n_left;
    logic [COORD_BITS-1:0] n_right;
    logic [COORD_BITS-1:0] n_top;
    logic [COORD_BITS-1:0] n_bottom;
    logic [COL_BITS-1:0]   n_colour;

    logic       w_accept;
    t_val       w_w;
    t_val       w_h;
    t_val       w_xe_c;
    t_val       w_ye_c;
    logic       w_fill_ok;
    t_seg       w_pt;
    t_seg       w_ln;
    logic       w_is_cmd;
    logic [2:0] w_first;
    t_start     w_st;
    t_seg       c_line;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_is_cmd = (i_op == OP_CMD);

    assign w_w = t_val'(i_width);
    assign w_h = t_val'(i_height);

    // A fill clips only its far corner.
    assign w_xe_c    = (t_val'(i_x_end) >= w_w) ? (w_w - t_val'(1)) : t_val'(i_x_end);
    assign w_ye_c    = (t_val'(i_y_end) >= w_h) ? (w_h - t_val'(1)) : t_val'(i_y_end);
    assign w_fill_ok = (t_val'(i_x_start) <= w_xe_c) && (t_val'(i_y_start) <= w_ye_c);

    assign w_pt = setup_line(t_val'(i_x_start), t_val'(i_y_start), 1'b1, t_val'(1), w_w, w_h);
    assign w_ln = setup_line(t_val'(i_x_start), t_val'(i_y_start),
                             (i_shape_kind == KIND_LINE_H), t_val'(i_line_length), w_w, w_h);

    // One outline search serves both a new command and the step to the next side.
    assign w_first = w_is_cmd ? 3'd0 : ({1'b0, r_seg} + 3'd1);
    assign w_st = start_seg(w_is_cmd ? t_val'(i_x_start) : t_val'(r_left),
                            w_is_cmd ? t_val'(i_x_end)   : t_val'(r_right),
                            w_is_cmd ? t_val'(i_y_start) : t_val'(r_top),
                            w_is_cmd ? t_val'(i_y_end)   : t_val'(r_bottom),
                            w_first, w_w, w_h);

    always_comb begin
        n_busy   = r_busy;
        n_kind   = r_kind;
        n_seg    = r_seg;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_colour = r_colour;
        c_line   = '0;
        o_push   = 1'b0;
        o_pix    = '0;
        if (w_accept) begin
            if (w_is_cmd) begin
                if (r_busy) begin
                    o_push         = 1'b1;
                    o_pix.rejected = 1'b1;
                end else if (i_shape_kind <= KIND_FILL) begin
                    n_kind   = i_shape_kind;
                    n_colour = to_rgb565(i_colour_argb);
                    n_seg    = SEG_TOP;
                    case (i_shape_kind)
                        KIND_POINT: begin
                            c_line = w_pt;
                        end
                        KIND_LINE_H, KIND_LINE_V: begin
                            c_line = w_ln;
                        end
                        KIND_OUTLINE: begin
                            n_left   = i_x_start;
                            n_right  = i_x_end;
                            n_top    = i_y_start;
                            n_bottom = i_y_end;
                            c_line   = w_st.line;
                            n_seg    = w_st.seg;
                        end
                        default: begin
                            n_left    = i_x_start;
                            n_right   = COORD_BITS'(w_xe_c);
                            n_top     = i_y_start;
                            n_bottom  = COORD_BITS'(w_ye_c);
                            c_line.ok = w_fill_ok;
                            c_line.cx = SCR_BITS'(i_x_start);
                            c_line.cy = SCR_BITS'(i_y_start);
                            c_line.sx = SCR_BITS'(w_xe_c);
                            c_line.sy = SCR_BITS'(w_ye_c);
                        end
                    endcase
                    n_busy = c_line.ok;
                    if (c_line.ok) begin
                        n_cx = c_line.cx;
                        n_cy = c_line.cy;
                        n_sx = c_line.sx;
                        n_sy = c_line.sy;
                    end
                end
            end else if (r_busy) begin
                o_push       = 1'b1;
                o_pix.x      = r_cx;
                o_pix.y      = r_cy;
                o_pix.colour = r_colour;
                if (r_cx < r_sx) begin
                    n_cx = r_cx + 1'b1;
                end else if (r_cy < r_sy) begin
                    n_cy = r_cy + 1'b1;
                    n_cx = (r_kind == KIND_FILL) ? SCR_BITS'(r_left) : r_sx;
                end else if ((r_kind == KIND_OUTLINE) && (r_seg != SEG_RIGHT) && w_st.ok) begin
                    n_seg = w_st.seg;
                    n_cx  = w_st.line.cx;
                    n_cy  = w_st.line.cy;
                    n_sx  = w_st.line.sx;
                    n_sy  = w_st.line.sy;
                end else begin
                    o_pix.last = 1'b1;
                    n_busy     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= KIND_POINT;
            r_seg  <= SEG_TOP;
        end else begin
            r_busy <= n_busy;
            r_kind <= n_kind;
            r_seg  <= n_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_left   <= n_left;
        r_right  <= n_right;
        r_top    <= n_top;
        r_bottom <= n_bottom;
        r_colour <= n_colour;
    end

    `RRL_ASSERT_NEXT(a_last_ends_busy, i_clk, i_rst_n, (o_push && o_pix.last), !r_busy, "engine still busy after final word")
    `RRL_ASSERT_NOW(a_cursor_in_span, i_clk, i_rst_n, r_busy, ((r_cx <= r_sx) && (r_cy <= r_sy)), "cursor beyond span")

endmodule

// File: rtl/rrl_back.sv
`timescale 1ns / 1ps
`include "rgb565_rect_line_draw_engine_assert.svh"

module rrl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrl_pkg::DIM_BITS-1:0]  i_width,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  rrl_pkg::t_pix                 i_pix,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rrl_pkg::ADDR_BITS-1:0] o_address,
    output logic [rrl_pkg::COL_BITS-1:0]  o_colour,
    output logic                          o_last,
    output logic                          o_rejected
);
    import rrl_pkg::*;

    logic                          r_s1_valid;
    logic [ADDR_BITS-1:0]          r_s1_prod;
    logic [SCR_BITS-1:0]           r_s1_x;
    logic [COL_BITS-1:0]           r_s1_colour;
    logic                          r_s1_last;
    logic                          r_s1_rej;

    logic                          r_out_valid;
    logic [ADDR_BITS-1:0]          r_addr;
    logic [COL_BITS-1:0]           r_col;
    logic                          r_last;
    logic                          r_rej;

    logic                          w_adv;
    logic                          w_s1_load;
    logic [SCR_BITS+DIM_BITS-1:0]  w_prod;

    assign w_adv     = !r_out_valid || i_ready;
    assign w_s1_load = !r_s1_valid || w_adv;
    assign o_pop     = !i_empty && w_s1_load;

    // Row base: row times stride; the user must keep the stride steady while words are in flight, not enforced here.
    assign w_prod = {{DIM_BITS{1'b0}}, i_pix.y} * {{SCR_BITS{1'b0}}, i_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= o_pop;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod   <= ADDR_BITS'(w_prod);
            r_s1_x      <= i_pix.x;
            r_s1_colour <= i_pix.colour;
            r_s1_last   <= i_pix.last;
            r_s1_rej    <= i_pix.rejected;
        end
        if (w_adv && r_s1_valid) begin
            r_addr <= r_s1_prod + ADDR_BITS'(r_s1_x);
            r_col  <= r_s1_colour;
            r_last <= r_s1_last;
            r_rej  <= r_s1_rej;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_address  = r_addr;
    assign o_colour   = r_col;
    assign o_last     = r_last;
    assign o_rejected = r_rej;

    `RRL_ASSERT_NOW(a_reject_is_blank, i_clk, i_rst_n, (r_out_valid && r_rej), ((r_addr == '0) && (r_col == '0) && !r_last), "rejected word carries data")

endmodule

// File: rtl/rgb565_rect_line_draw_engine.sv
`timescale 1ns / 1ps

// Drawing engine for an RGB565 framebuffer: each input word is either a draw command
// (tuser 0) or a drawing tick (tuser 1), and one word is taken every clock while the
// internal four-entry queue has room. A busy tick yields one pixel write per clock
// while ticks arrive and the queue has room, lines left to right then top to bottom,
// tlast on the last write of a shape; a command that arrives while a shape is in
// progress comes back as one word with tuser set and zero data. The command decoder
// and cursor update push into the queue in the same cycle as a word is taken, and the
// address path behind the queue (a 12 x 13 bit row multiply, then the column add) adds
// two register stages. The stride and height registers, values 0 and above 4096 acting
// as 1 and 4096, are to be written only while the engine is idle and its output drained.
module rgb565_rect_line_draw_engine #(
    parameter int COORD_BITS = rrl_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // shape_kind, x_start, y_start, x_end, y_end, line_length, colour_argb, zero fill
    input  logic [((rrl_pkg::KIND_BITS + 4 * COORD_BITS + rrl_pkg::LEN_BITS
                    + rrl_pkg::RGB_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op
    input  logic [0:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // pixel_address, pixel_colour
    output logic [rrl_pkg::ADDR_BITS + rrl_pkg::COL_BITS - 1:0] m_axis_tdata,
    output logic                         m_axis_tlast,
    // rejected
    output logic [0:0]                   m_axis_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [rrl_pkg::DIM_BITS-1:0] i_cfg_data
);
    import rrl_pkg::*;

    localparam int OFS_XS  = KIND_BITS;
    localparam int OFS_YS  = OFS_XS + COORD_BITS;
    localparam int OFS_XE  = OFS_YS + COORD_BITS;
    localparam int OFS_YE  = OFS_XE + COORD_BITS;
    localparam int OFS_LEN = OFS_YE + COORD_BITS;
    localparam int OFS_COL = OFS_LEN + LEN_BITS;

    logic [DIM_BITS-1:0]  r_stride;
    logic [DIM_BITS-1:0]  r_height;
    logic [DIM_BITS-1:0]  w_width;
    logic [DIM_BITS-1:0]  w_height;

    logic                 w_full;
    logic                 w_empty;
    logic                 w_push;
    logic                 w_pop;
    t_pix                 w_push_pix;
    t_pix                 w_pop_pix;
    logic [ADDR_BITS-1:0] w_address;
    logic [COL_BITS-1:0]  w_colour;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STRIDE: r_stride <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_stride <= r_stride;
            endcase
        end
    end

    assign w_width  = eff_dim(r_stride);
    assign w_height = eff_dim(r_height);

    rrl_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (w_width),
        .i_height      (w_height),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser[0]),
        .i_shape_kind  (s_axis_tdata[KIND_BITS-1:0]),
        .i_x_start     (s_axis_tdata[OFS_XS +: COORD_BITS]),
        .i_y_start     (s_axis_tdata[OFS_YS +: COORD_BITS]),
        .i_x_end       (s_axis_tdata[OFS_XE +: COORD_BITS]),
        .i_y_end       (s_axis_tdata[OFS_YE +: COORD_BITS]),
        .i_line_length (s_axis_tdata[OFS_LEN +: LEN_BITS]),
        .i_colour_argb (s_axis_tdata[OFS_COL +: RGB_BITS]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_pix         (w_push_pix)
    );

    rrl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_pix),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_pix)
    );

    rrl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (w_width),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_pix      (w_pop_pix),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_address  (w_address),
        .o_colour   (w_colour),
        .o_last     (m_axis_tlast),
        .o_rejected (m_axis_tuser[0])
    );

    assign m_axis_tdata = {w_colour, w_address};

endmodule
